// ===== hw/rtl/three_segment_log_path_loss_assert.svh =====
// assertion macros for the path loss block
`ifndef THREE_SEGMENT_LOG_PATH_LOSS_ASSERT_SVH
`define THREE_SEGMENT_LOG_PATH_LOSS_ASSERT_SVH
`ifndef SYNTH
`define TSLPL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tslpl assertion failed");
`define TSLPL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tslpl assertion failed");
`else
`define TSLPL_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TSLPL_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/tslpl_pkg.sv =====
`default_nettype none
package tslpl_pkg;

  localparam int DISTANCE_WIDTH = 24;
  localparam int LOG_TABLE_DEPTH = 64;

  localparam int TX_W = 16;
  localparam int BRK_W = 24;
  localparam int EXP_W = 12;
  localparam int REF_W = 16;
  localparam int CFG_W = 24;
  localparam int CFG_IDX_W = 3;

  localparam int FRAC_Q = 16;
  localparam int TEN_LOG10_TWO_Q16 = 197283;
  localparam int K_W = $clog2(TEN_LOG10_TWO_Q16 + 1);
  localparam int POS_W = $clog2(DISTANCE_WIDTH);
  localparam int IDX_W = $clog2(LOG_TABLE_DEPTH + 1);
  localparam int ENTRY_W = FRAC_Q + 1;
  localparam int LOG_W = $clog2(DISTANCE_WIDTH + 1) + FRAC_Q;
  localparam int DIFF_W = LOG_W + 1;
  localparam int EK_W = EXP_W + K_W;
  localparam int TERM_W = EK_W + 1 + DIFF_W;
  localparam int SUM_W = TERM_W + 2;
  localparam int LOSS_SHIFT = 32;
  localparam int LOSS_W = SUM_W - LOSS_SHIFT;
  localparam int RX_W = LOSS_W + 1;

  localparam int LOG_LAT = 3;
  localparam int OUT_LAT = 8;
  localparam int PIPE_D = OUT_LAT - 1;

  localparam logic [BRK_W-1:0] BREAK_NEAR_RST = BRK_W'(256);
  localparam logic [BRK_W-1:0] BREAK_MIDDLE_RST = BRK_W'(51200);
  localparam logic [BRK_W-1:0] BREAK_FAR_RST = BRK_W'(128000);
  localparam logic [EXP_W-1:0] EXP_NEAR_RST = EXP_W'(486);
  localparam logic [EXP_W-1:0] EXP_MIDDLE_RST = EXP_W'(973);
  localparam logic [EXP_W-1:0] EXP_FAR_RST = EXP_W'(973);
  localparam logic [REF_W-1:0] REF_LOSS_RST = REF_W'(11949);

  localparam logic signed [TX_W-1:0] TX_POS_MAX = {1'b0, {(TX_W-1){1'b1}}};
  localparam logic signed [TX_W-1:0] TX_NEG_MIN = {1'b1, {(TX_W-1){1'b0}}};

  typedef enum logic [1:0] {
    SEG_NONE   = 2'd0,
    SEG_NEAR   = 2'd1,
    SEG_MIDDLE = 2'd2,
    SEG_FAR    = 2'd3
  } seg_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BREAK_NEAR      = 3'd0,
    REG_BREAK_MIDDLE    = 3'd1,
    REG_BREAK_FAR       = 3'd2,
    REG_EXPONENT_NEAR   = 3'd3,
    REG_EXPONENT_MIDDLE = 3'd4,
    REG_EXPONENT_FAR    = 3'd5,
    REG_REFERENCE_LOSS  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [LOG_W-1:0] span;
    logic [LOG_W-1:0] near;
    logic [LOG_W-1:0] middle;
    logic [LOG_W-1:0] far;
  } log_set_t;

  typedef struct packed {
    logic [EXP_W-1:0] exp_near;
    logic [EXP_W-1:0] exp_middle;
    logic [EXP_W-1:0] exp_far;
    logic [REF_W-1:0] ref_loss;
  } loss_cfg_t;

  typedef logic [ENTRY_W-1:0] log_tab_t [LOG_TABLE_DEPTH+1];

  // log2(1 + i/depth) in q16, squaring method
  function automatic log_tab_t log_tab_build();
    log_tab_t tab;
    longint unsigned y;
    logic [ENTRY_W-1:0] r;
    for (int i = 0; i <= LOG_TABLE_DEPTH; i++) begin
      if (i == LOG_TABLE_DEPTH) begin
        tab[i] = ENTRY_W'(1) << FRAC_Q;
      end else begin
        y = (64'(LOG_TABLE_DEPTH + i) << 30) / 64'(LOG_TABLE_DEPTH);
        r = '0;
        for (int k = 0; k < FRAC_Q; k++) begin
          y = (y * y) >> 30;
          r = r << 1;
          if (y >= (64'd1 << 31)) begin
            r[0] = 1'b1;
            y = y >> 1;
          end
        end
        tab[i] = r;
      end
    end
    return tab;
  endfunction

  localparam log_tab_t LOG_TAB = log_tab_build();

endpackage
`default_nettype wire

// ===== hw/rtl/three_segment_log_path_loss.sv =====
`default_nettype none
`include "three_segment_log_path_loss_assert.svh"
// three segment log distance path loss
// input: start with in_tx_power (dBm, signed q8.8) and in_distance (m, q16.8);
//   a word is taken at every clock edge where start is high and busy is low.
//   busy stays low: a new word can enter on every cycle.
// output: out_valid strobes for one cycle with out_rx_power (dBm, signed
//   q8.8, clamped), out_segment and out_saturated. the receiver cannot stall,
//   so results leave in input order, one per accepted word.
// throughput: one word per cycle; the pipeline depth is set by the log2
//   lanes (leading one, normalize, table), the loss path (ratio, multiply,
//   two level sum) and the subtract and clamp register.
// config: cfg_we, cfg_index, cfg_wdata write the breaks, exponents and
//   reference loss; write only while no word is in flight.
// reset: rst_n low clears the valid pipeline and loads the default breaks,
//   exponents and reference loss.
module three_segment_log_path_loss (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [tslpl_pkg::TX_W-1:0]    in_tx_power,
  input  logic [tslpl_pkg::DISTANCE_WIDTH-1:0] in_distance,
  input  logic                                 cfg_we,
  input  logic [tslpl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tslpl_pkg::CFG_W-1:0]          cfg_wdata,
  output logic                                 out_valid,
  output logic signed [tslpl_pkg::TX_W-1:0]    out_rx_power,
  output logic [1:0]                           out_segment,
  output logic                                 out_saturated
);
  import tslpl_pkg::*;

  logic [BRK_W-1:0] brk_near_r, brk_near_nxt;
  logic [BRK_W-1:0] brk_middle_r, brk_middle_nxt;
  logic [BRK_W-1:0] brk_far_r, brk_far_nxt;
  logic [EXP_W-1:0] exp_near_r, exp_near_nxt;
  logic [EXP_W-1:0] exp_middle_r, exp_middle_nxt;
  logic [EXP_W-1:0] exp_far_r, exp_far_nxt;
  logic [REF_W-1:0] ref_loss_r, ref_loss_nxt;

  logic [DISTANCE_WIDTH-1:0] bd_near;
  logic [DISTANCE_WIDTH-1:0] bd_middle;
  logic [DISTANCE_WIDTH-1:0] bd_far;

  logic                   accept;
  logic [OUT_LAT-1:0]     vld_r, vld_nxt;
  seg_t                   seg_nxt;
  seg_t                   seg_pipe_r [PIPE_D];
  logic signed [TX_W-1:0] tx_pipe_r [PIPE_D];

  log_set_t               lg;
  loss_cfg_t              lcfg;
  logic signed [LOSS_W-1:0] loss;

  logic signed [RX_W-1:0] rx_full;
  logic                   ovf;
  logic signed [TX_W-1:0] rx_nxt, rx_r;
  logic                   sat_nxt, sat_r;
  seg_t                   seg_out_r;

  assign busy = 1'b0;
  assign accept = start && !busy;

  // config write port
  always_comb begin
    brk_near_nxt = brk_near_r;
    brk_middle_nxt = brk_middle_r;
    brk_far_nxt = brk_far_r;
    exp_near_nxt = exp_near_r;
    exp_middle_nxt = exp_middle_r;
    exp_far_nxt = exp_far_r;
    ref_loss_nxt = ref_loss_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_BREAK_NEAR:      brk_near_nxt = cfg_wdata[BRK_W-1:0];
        REG_BREAK_MIDDLE:    brk_middle_nxt = cfg_wdata[BRK_W-1:0];
        REG_BREAK_FAR:       brk_far_nxt = cfg_wdata[BRK_W-1:0];
        REG_EXPONENT_NEAR:   exp_near_nxt = cfg_wdata[EXP_W-1:0];
        REG_EXPONENT_MIDDLE: exp_middle_nxt = cfg_wdata[EXP_W-1:0];
        REG_EXPONENT_FAR:    exp_far_nxt = cfg_wdata[EXP_W-1:0];
        REG_REFERENCE_LOSS:  ref_loss_nxt = cfg_wdata[REF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign bd_near = DISTANCE_WIDTH'(brk_near_r);
  assign bd_middle = DISTANCE_WIDTH'(brk_middle_r);
  assign bd_far = DISTANCE_WIDTH'(brk_far_r);

  // segment choice
  always_comb begin
    priority if (in_distance < bd_near) begin
      seg_nxt = SEG_NONE;
    end else if (in_distance < bd_middle) begin
      seg_nxt = SEG_NEAR;
    end else if (in_distance < bd_far) begin
      seg_nxt = SEG_MIDDLE;
    end else begin
      seg_nxt = SEG_FAR;
    end
  end

  assign vld_nxt = {vld_r[OUT_LAT-2:0], accept};

  tslpl_log2 u_log_dist (.clk(clk), .x(in_distance), .log_q(lg.span));
  tslpl_log2 u_log_near (.clk(clk), .x(bd_near), .log_q(lg.near));
  tslpl_log2 u_log_middle (.clk(clk), .x(bd_middle), .log_q(lg.middle));
  tslpl_log2 u_log_far (.clk(clk), .x(bd_far), .log_q(lg.far));

  assign lcfg.exp_near = exp_near_r;
  assign lcfg.exp_middle = exp_middle_r;
  assign lcfg.exp_far = exp_far_r;
  assign lcfg.ref_loss = ref_loss_r;

  tslpl_loss u_loss (
    .clk  (clk),
    .cfg  (lcfg),
    .seg  (seg_pipe_r[LOG_LAT-1]),
    .lg   (lg),
    .loss (loss)
  );

  // subtract and clamp; in SEG_NONE the tx power passes through unchanged
  always_comb begin
    rx_full = RX_W'(tx_pipe_r[PIPE_D-1]) - RX_W'(loss);
    ovf = (rx_full[RX_W-1:TX_W-1] != '0) && (rx_full[RX_W-1:TX_W-1] != '1);
    rx_nxt = rx_full[TX_W-1:0];
    sat_nxt = 1'b0;
    if (seg_pipe_r[PIPE_D-1] == SEG_NONE) begin
      rx_nxt = tx_pipe_r[PIPE_D-1];
    end else if (ovf) begin
      rx_nxt = rx_full[RX_W-1] ? TX_NEG_MIN : TX_POS_MAX;
      sat_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      brk_near_r <= BREAK_NEAR_RST;
      brk_middle_r <= BREAK_MIDDLE_RST;
      brk_far_r <= BREAK_FAR_RST;
      exp_near_r <= EXP_NEAR_RST;
      exp_middle_r <= EXP_MIDDLE_RST;
      exp_far_r <= EXP_FAR_RST;
      ref_loss_r <= REF_LOSS_RST;
    end else begin
      vld_r <= vld_nxt;
      brk_near_r <= brk_near_nxt;
      brk_middle_r <= brk_middle_nxt;
      brk_far_r <= brk_far_nxt;
      exp_near_r <= exp_near_nxt;
      exp_middle_r <= exp_middle_nxt;
      exp_far_r <= exp_far_nxt;
      ref_loss_r <= ref_loss_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tx_pipe_r[0] <= in_tx_power;
    seg_pipe_r[0] <= seg_nxt;
    for (int k = 1; k < PIPE_D; k++) begin
      tx_pipe_r[k] <= tx_pipe_r[k-1];
      seg_pipe_r[k] <= seg_pipe_r[k-1];
    end
    rx_r <= rx_nxt;
    sat_r <= sat_nxt;
    seg_out_r <= seg_pipe_r[PIPE_D-1];
  end

  assign out_valid = vld_r[OUT_LAT-1];
  assign out_rx_power = rx_r;
  assign out_segment = seg_out_r;
  assign out_saturated = sat_r && vld_r[OUT_LAT-1];

  `TSLPL_ASSERT_IMP(a_out_follows_accept, clk, rst_n, out_valid, $past(start && !busy, OUT_LAT))
  `TSLPL_ASSERT_IMP(a_no_loss_pass, clk, rst_n, out_valid && out_segment == SEG_NONE, out_rx_power == $past(in_tx_power, OUT_LAT) && !out_saturated)
  `TSLPL_ASSERT_IMP(a_sat_clamped, clk, rst_n, out_saturated, out_rx_power == TX_POS_MAX || out_rx_power == TX_NEG_MIN)
  `TSLPL_ASSERT_NXT(a_ref_write, clk, rst_n, cfg_we && cfg_index == REG_REFERENCE_LOSS, ref_loss_r == $past(cfg_wdata[REF_W-1:0]))

endmodule
`default_nettype wire

// ===== hw/rtl/tslpl_log2.sv =====
`default_nettype none
module tslpl_log2 (
  input  logic                             clk,
  input  logic [tslpl_pkg::DISTANCE_WIDTH-1:0] x,
  output logic [tslpl_pkg::LOG_W-1:0]      log_q
);
  import tslpl_pkg::*;

  localparam int W = DISTANCE_WIDTH;
  localparam int PROD_W = W - 1 + IDX_W;

  logic [W-1:0]       x_r;
  logic [POS_W-1:0]   pos_nxt;
  logic [POS_W-1:0]   pos_r;
  logic [POS_W-1:0]   pos2_r;
  logic [POS_W-1:0]   shamt;
  logic [W-1:0]       shifted;
  logic [W-2:0]       frac_nxt;
  logic [W-2:0]       frac_r;
  logic [PROD_W-1:0]  prod;
  logic [IDX_W-1:0]   idx;
  logic [LOG_W-1:0]   log_nxt;
  logic [LOG_W-1:0]   log_r;

  // leading one
  always_comb begin
    pos_nxt = '0;
    for (int i = 1; i < W; i++) begin
      if (x[i]) begin
        pos_nxt = POS_W'(i);
      end
    end
  end

  // left align the bits below the leading one
  always_comb begin
    shamt = POS_W'(W - 1) - pos_r;
    shifted = x_r << shamt;
    frac_nxt = shifted[W-2:0];
  end

  // rounded table index, then integer part plus table entry
  always_comb begin
    prod = PROD_W'(frac_r) * PROD_W'(LOG_TABLE_DEPTH) + (PROD_W'(1) << (W - 2));
    idx = prod[PROD_W-1:W-1];
    log_nxt = LOG_W'({pos2_r, {FRAC_Q{1'b0}}}) + LOG_W'(LOG_TAB[idx]);
  end

  always_ff @(posedge clk) begin
    x_r <= x;
    pos_r <= pos_nxt;
    frac_r <= frac_nxt;
    pos2_r <= pos_r;
    log_r <= log_nxt;
  end

  assign log_q = log_r;

endmodule
`default_nettype wire

// ===== hw/rtl/tslpl_loss.sv =====
`default_nettype none
module tslpl_loss (
  input  logic                               clk,
  input  tslpl_pkg::loss_cfg_t               cfg,
  input  tslpl_pkg::seg_t                    seg,
  input  tslpl_pkg::log_set_t                lg,
  output logic signed [tslpl_pkg::LOSS_W-1:0] loss
);
  import tslpl_pkg::*;

  logic [EK_W-1:0]          ek_nxt [3];
  logic [EK_W-1:0]          ek_r [3];
  logic signed [DIFF_W-1:0] diff_nxt [3];
  logic signed [DIFF_W-1:0] diff_r [3];
  logic signed [TERM_W-1:0] term_nxt [3];
  logic signed [TERM_W-1:0] term_r [3];
  logic signed [SUM_W-1:0]  bias;
  logic signed [SUM_W-1:0]  s01_nxt;
  logic signed [SUM_W-1:0]  s01_r;
  logic signed [SUM_W-1:0]  s2_nxt;
  logic signed [SUM_W-1:0]  s2_r;
  logic signed [SUM_W-1:0]  sum;
  logic signed [LOSS_W-1:0] loss_nxt;
  logic signed [LOSS_W-1:0] loss_r;

  function automatic logic signed [DIFF_W-1:0] ldiff(
    input logic [LOG_W-1:0] a,
    input logic [LOG_W-1:0] b
  );
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  // exponent times 10*log10(2); the user must keep config static while items flow, the block does not enforce it
  always_comb begin
    ek_nxt[0] = EK_W'(cfg.exp_near) * EK_W'(TEN_LOG10_TWO_Q16);
    ek_nxt[1] = EK_W'(cfg.exp_middle) * EK_W'(TEN_LOG10_TWO_Q16);
    ek_nxt[2] = EK_W'(cfg.exp_far) * EK_W'(TEN_LOG10_TWO_Q16);
  end

  // log ratios of the segments crossed
  always_comb begin
    diff_nxt[0] = '0;
    diff_nxt[1] = '0;
    diff_nxt[2] = '0;
    unique case (seg)
      SEG_NONE: begin
      end
      SEG_NEAR: begin
        diff_nxt[0] = ldiff(lg.span, lg.near);
      end
      SEG_MIDDLE: begin
        diff_nxt[0] = ldiff(lg.middle, lg.near);
        diff_nxt[1] = ldiff(lg.span, lg.middle);
      end
      SEG_FAR: begin
        diff_nxt[0] = ldiff(lg.middle, lg.near);
        diff_nxt[1] = ldiff(lg.far, lg.middle);
        diff_nxt[2] = ldiff(lg.span, lg.far);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      term_nxt[k] = $signed({1'b0, ek_r[k]}) * diff_r[k];
    end
  end

  // reference loss in q40 plus the rounding half
  assign bias = {{(SUM_W - REF_W - LOSS_SHIFT){1'b0}}, cfg.ref_loss, 1'b1,
                 {(LOSS_SHIFT - 1){1'b0}}};

  always_comb begin
    s01_nxt = SUM_W'(term_r[0]) + SUM_W'(term_r[1]);
    s2_nxt = SUM_W'(term_r[2]) + bias;
    sum = s01_r + s2_r;
    loss_nxt = sum[SUM_W-1:LOSS_SHIFT];
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      ek_r[k] <= ek_nxt[k];
      diff_r[k] <= diff_nxt[k];
      term_r[k] <= term_nxt[k];
    end
    s01_r <= s01_nxt;
    s2_r <= s2_nxt;
    loss_r <= loss_nxt;
  end

  assign loss = loss_r;

endmodule
`default_nettype wire
